// ----- sv/dtts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtts_pkg
// Types, constants and helper functions shared by the trigger scheduler.
// ----------------------------------------------------------------------------
package dtts_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int TIME_W  = 17;

  // Latest time of a day, 23:59:59 packed as hour, minute, second.
  localparam logic [TIME_W-1:0] END_OF_DAY = {5'd23, 6'd59, 6'd59};

  // Operation codes.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_FIRE    = 2'd1;
  localparam logic [1:0] KIND_NOFIRE  = 2'd2;
  localparam logic [1:0] KIND_NOTHING = 2'd3;

  // Trigger types.
  localparam logic [1:0] TT_ONCE    = 2'd0;
  localparam logic [1:0] TT_MDAY    = 2'd1;
  localparam logic [1:0] TT_WEEKLY  = 2'd2;
  localparam logic [1:0] TT_MONTHLY = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [3:0]  slot;
    logic [1:0]  trigger_type;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] mday_mask;
    logic [6:0]  wday_mask;
    logic [11:0] month_mask;
    logic [4:0]  day_of_month;
    logic [2:0]  day_of_week;
    logic [3:0]  month;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] out_slot;
    logic       status;
    logic       freed;
    logic       last;
    logic [4:0] popped_count;
  } out_beat_t;

  // One stored trigger.
  typedef struct packed {
    logic [TIME_W-1:0] trig_time;
    logic [1:0]        trig_kind;
    logic [31:0]       mday_m;
    logic [6:0]        wday_m;
    logic [11:0]       month_m;
  } entry_t;

  // Does a popped trigger fire on the given date?
  function automatic logic fires(entry_t e, logic [4:0] mday, logic [2:0] wday,
                                 logic [3:0] mon);
    logic md;
    logic wd;
    logic mo;
    logic r;
    md = e.mday_m[mday];
    wd = (wday < 3'd7) ? e.wday_m[wday] : 1'b0;
    mo = (mon < 4'd12) ? e.month_m[mon] : 1'b0;
    case (e.trig_kind)
      TT_ONCE:   r = 1'b1;
      TT_MDAY:   r = md;
      TT_WEEKLY: r = wd;
      default:   r = mo & md;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/dtts_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtts_mem
// Trigger store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dtts_mem (
  input  logic                 clk,
  input  logic                 we,
  input  logic [dtts_pkg::IDX_W-1:0] waddr,
  input  dtts_pkg::entry_t     wdata,
  input  logic [dtts_pkg::IDX_W-1:0] raddr,
  output dtts_pkg::entry_t     rdata
);
  import dtts_pkg::*;

  entry_t mem [SLOTS];

  // Write and synchronous read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/daily_time_trigger_scheduler_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_time_trigger_scheduler_unit
// Time-of-day trigger scheduler with pending and done-today pools.
// ----------------------------------------------------------------------------
// An add or remove passes through the ACK state and gives one ack beat; it
// waits there while the output register is full. A tick scans the trigger
// store once for each popped trigger and once more to find none left: each
// scan reads all SLOTS entries through the single read port. One item is
// worked on at a time; a result beat waits in the output register without
// holding up the next input.
module daily_time_trigger_scheduler_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtts_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dtts_pkg::out_beat_t out_data
);
  import dtts_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_ACK, ST_TICK, ST_SCAN, ST_DECIDE} state_t;

  state_t            state_r;
  in_beat_t          in_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOTS-1:0]  en_r;
  logic [SLOTS-1:0]  pool_r;
  logic              pid_r;
  logic [TIME_W-1:0] cur_time_r;
  logic [4:0]        cur_day_r;
  logic              new_day_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_slot_r;
  entry_t            best_r;
  logic              held_v_r;
  out_beat_t         held_r;
  logic [4:0]        n_r;
  logic              out_valid_r;
  out_beat_t         out_r;

  logic              out_free;
  logic              out_load;
  logic [TIME_W-1:0] in_time;
  logic [IDX_W-1:0]  in_idx;
  logic              in_range;
  logic              occupied;
  logic              add_ok;
  logic              rem_ok;
  logic              mem_we;
  entry_t            wentry;
  entry_t            rentry;
  logic [IDX_W-1:0]  rslot;
  logic              rdue;
  out_beat_t         held_fin;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Decode of the latched item.
  assign in_time  = {in_r.hour, in_r.minute, in_r.second};
  assign in_idx   = in_r.slot[IDX_W-1:0];
  assign in_range = ({1'b0, in_r.slot} < (SLOT_W + 1)'(SLOTS));
  assign occupied = !in_range || valid_r[in_idx];
  assign add_ok   = (in_r.operation == OP_ADD) && !occupied;
  assign rem_ok   = (in_r.operation == OP_REMOVE) && in_range && valid_r[in_idx];
  assign mem_we   = (state_r == ST_ACK) && out_free && add_ok;

  // A result beat is loaded for an ack, for a pop that pushes out the
  // previous one, and for the closing beat of a tick.
  assign out_load = out_free &&
                    ((state_r == ST_ACK) ||
                     ((state_r == ST_DECIDE) && (!found_r || held_v_r)));

  // The held pop marked as the last beat of its tick.
  always_comb begin
    held_fin      = held_r;
    held_fin.last = 1'b1;
  end

  // New entry for an add.
  always_comb begin
    wentry.trig_time = in_time;
    wentry.trig_kind = in_r.trigger_type;
    wentry.mday_m    = in_r.mday_mask;
    wentry.wday_m    = in_r.wday_mask;
    wentry.month_m   = in_r.month_mask;
  end

  dtts_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (in_idx),
    .wdata (wentry),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rentry)
  );

  // Entry returning from the store belongs to the slot read in the previous cycle.
  assign rslot = IDX_W'(cnt_r - CNT_W'(1));
  assign rdue  = valid_r[rslot] && (pool_r[rslot] == pid_r) &&
                 (rentry.trig_time <= cur_time_r) &&
                 (!found_r || (rentry.trig_time < best_r.trig_time));

  // Control sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      en_r        <= '0;
      pid_r       <= 1'b1;
      cur_time_r  <= '0;
      cur_day_r   <= 5'd1;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_ready);
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            in_r    <= in_data;
            state_r <= (in_data.operation == OP_TICK) ? ST_TICK : ST_ACK;
          end
        end
        ST_ACK: begin
          if (out_free) begin
            out_r.kind          <= KIND_ACK;
            out_r.out_slot      <= in_r.slot;
            out_r.freed         <= 1'b0;
            out_r.last          <= 1'b1;
            out_r.popped_count  <= '0;
            out_r.status        <= !(add_ok || rem_ok);
            if (add_ok) begin
              valid_r[in_idx] <= 1'b1;
              en_r[in_idx]    <= 1'b1;
              pool_r[in_idx]  <= (in_time <= cur_time_r) ? !pid_r : pid_r;
            end else if (rem_ok) begin
              en_r[in_idx] <= 1'b0;
            end
            state_r <= ST_IDLE;
          end
        end
        ST_TICK: begin
          new_day_r  <= (in_r.day_of_month != cur_day_r);
          cur_day_r  <= in_r.day_of_month;
          cur_time_r <= (in_r.day_of_month != cur_day_r) ? END_OF_DAY : in_time;
          n_r        <= '0;
          cnt_r      <= '0;
          found_r    <= 1'b0;
          state_r    <= ST_SCAN;
        end
        ST_SCAN: begin
          // Track the earliest due pending trigger, lowest slot on a tie.
          if (cnt_r != '0 && rdue) begin
            found_r     <= 1'b1;
            best_slot_r <= rslot;
            best_r      <= rentry;
          end
          if (cnt_r == CNT_W'(SLOTS)) begin
            state_r <= ST_DECIDE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        ST_DECIDE: begin
          if (found_r) begin
            // The previous pop is known not to be the last one.
            if (!held_v_r || out_free) begin
              if (held_v_r) begin
                out_r <= held_r;
              end
              held_v_r              <= 1'b1;
              held_r.kind           <= fires(best_r, in_r.day_of_month, in_r.day_of_week,
                                             in_r.month) ? KIND_FIRE : KIND_NOFIRE;
              held_r.out_slot       <= SLOT_W'(best_slot_r);
              held_r.status         <= 1'b0;
              held_r.freed          <= !en_r[best_slot_r];
              held_r.last           <= 1'b0;
              held_r.popped_count   <= n_r + 5'd1;
              n_r                   <= n_r + 5'd1;
              if (en_r[best_slot_r]) begin
                pool_r[best_slot_r] <= !pid_r;
              end else begin
                valid_r[best_slot_r] <= 1'b0;
              end
              cnt_r   <= '0;
              found_r <= 1'b0;
              state_r <= ST_SCAN;
            end
          end else if (out_free) begin
            if (held_v_r) begin
              out_r <= held_fin;
            end else begin
              out_r.kind         <= KIND_NOTHING;
              out_r.out_slot     <= '0;
              out_r.status       <= 1'b0;
              out_r.freed        <= 1'b0;
              out_r.last         <= 1'b1;
              out_r.popped_count <= '0;
            end
            held_v_r <= 1'b0;
            if (new_day_r) begin
              pid_r <= !pid_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- bench/daily_time_trigger_scheduler_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_time_trigger_scheduler_unit_tb
// Self-checking bench for the time-of-day trigger scheduler. A directed table
// covers slot errors, removes, day changes and mask types. Random traffic
// follows, mostly adds and ticks over a few days. Every result beat is
// compared with a scheduler model kept inside the bench.
// ----------------------------------------------------------------------------
module daily_time_trigger_scheduler_unit_tb;
  import dtts_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int MAX_CYCLES = 2000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  daily_time_trigger_scheduler_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  // Scheduler state as the bench sees it.
  logic              held_q [SLOTS];
  logic              armed_q [SLOTS];
  logic              pool_q [SLOTS];
  logic [TIME_W-1:0] when_q [SLOTS];
  logic [1:0]        type_q [SLOTS];
  logic [50:0]       masks_q [SLOTS];
  logic              pend_pool;
  logic [TIME_W-1:0] now_time;
  logic [4:0]        today;

  out_beat_t expected_beats[$];
  int        errors;
  int        cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic date_matches(int s, in_beat_t b);
    logic md;
    logic wd;
    logic mo;
    md = masks_q[s][b.day_of_month];
    wd = (b.day_of_week < 3'd7) ? masks_q[s][32 + b.day_of_week] : 1'b0;
    mo = (b.month < 4'd12) ? masks_q[s][39 + b.month] : 1'b0;
    case (type_q[s])
      TT_ONCE:   return 1'b1;
      TT_MDAY:   return md;
      TT_WEEKLY: return wd;
      default:   return mo & md;
    endcase
  endfunction

  function automatic out_beat_t ack(logic [3:0] s, logic st);
    out_beat_t r;
    r = '0;
    r.kind = KIND_ACK;
    r.out_slot = s;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // Apply one accepted beat to the model and queue the results it causes.
  task automatic schedule_beat(in_beat_t b);
    logic [TIME_W-1:0] t;
    logic              new_day;
    int                n;
    int                best;
    out_beat_t         r;
    t = {b.hour, b.minute, b.second};
    case (b.operation)
      OP_ADD: begin
        if (held_q[b.slot]) begin
          expected_beats.push_back(ack(b.slot, 1'b1));
        end else begin
          held_q[b.slot] = 1'b1;
          armed_q[b.slot] = 1'b1;
          type_q[b.slot] = b.trigger_type;
          when_q[b.slot] = t;
          masks_q[b.slot] = {b.month_mask, b.wday_mask, b.mday_mask};
          pool_q[b.slot] = (t <= now_time) ? ~pend_pool : pend_pool;
          expected_beats.push_back(ack(b.slot, 1'b0));
        end
      end
      OP_REMOVE: begin
        if (!held_q[b.slot]) begin
          expected_beats.push_back(ack(b.slot, 1'b1));
        end else begin
          armed_q[b.slot] = 1'b0;
          expected_beats.push_back(ack(b.slot, 1'b0));
        end
      end
      OP_TICK: begin
        new_day = (b.day_of_month != today);
        today = b.day_of_month;
        now_time = new_day ? END_OF_DAY : t;
        n = 0;
        forever begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (held_q[i] && pool_q[i] == pend_pool && when_q[i] <= now_time &&
                (best < 0 || when_q[i] < when_q[best])) best = i;
          end
          if (best < 0 || n >= 16) break;
          r = '0;
          r.kind = date_matches(best, b) ? KIND_FIRE : KIND_NOFIRE;
          r.out_slot = best[3:0];
          if (armed_q[best]) begin
            pool_q[best] = ~pend_pool;
          end else begin
            held_q[best] = 1'b0;
            r.freed = 1'b1;
          end
          n++;
          r.popped_count = n[4:0];
          expected_beats.push_back(r);
        end
        if (n == 0) begin
          r = '0;
          r.kind = KIND_NOTHING;
          r.last = 1'b1;
          expected_beats.push_back(r);
        end else begin
          r = expected_beats.pop_back();
          r.last = 1'b1;
          expected_beats.push_back(r);
        end
        if (new_day) pend_pool = ~pend_pool;
      end
      default: begin
        expected_beats.push_back(ack(b.slot, 1'b1));
      end
    endcase
  endtask

  // Result checking at the rising edge.
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result beat %p", out_data);
      end else begin
        e = expected_beats.pop_front();
        if (out_data !== e) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", e, out_data);
        end
      end
    end
  end

  // Receiver stalls on its own pattern, with a quiet stretch.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b1;
    else if (cycles % 4000 < 800) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one beat, wait for acceptance, then model it.
  task automatic send_beat(in_beat_t b);
    in_valid = 1'b1;
    in_data = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    schedule_beat(b);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic in_beat_t make_beat(logic [1:0] op, logic [3:0] s, logic [1:0] tt,
                                         logic [4:0] h, logic [5:0] m, logic [5:0] sec,
                                         logic [4:0] dom);
    in_beat_t b;
    b = '0;
    b.operation = op;
    b.slot = s;
    b.trigger_type = tt;
    b.hour = h;
    b.minute = m;
    b.second = sec;
    b.mday_mask = 32'hFFFF_FFFF;
    b.wday_mask = 7'h7F;
    b.month_mask = 12'hFFF;
    b.day_of_month = dom;
    return b;
  endfunction

  function automatic in_beat_t random_beat(logic [4:0] dom, bit noisy);
    in_beat_t     b;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    b = raw[$bits(in_beat_t)-1:0];
    b.day_of_month = dom;
    b.day_of_week = 3'($urandom_range(0, 6));
    b.month = 4'($urandom_range(0, 11));
    b.hour = 5'($urandom_range(0, 23));
    b.minute = 6'($urandom_range(0, 59));
    b.second = 6'($urandom_range(0, 60));
    if ($urandom_range(0, 9) < 5) b.operation = OP_ADD;
    else if ($urandom_range(0, 3) == 0) b.operation = OP_REMOVE;
    else b.operation = OP_TICK;
    if (noisy) begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      b = raw[$bits(in_beat_t)-1:0];
      if (b.operation == OP_TICK && $urandom_range(0, 1)) b.day_of_month = dom;
    end
    return b;
  endfunction

  // Directed table; expected result typed in where obvious, else model only.
  in_beat_t  dir_beat [24];
  out_beat_t dir_exp [24];
  bit        dir_has [24];

  task automatic fill_directed();
    out_beat_t none;
    none = '0;
    none.kind = KIND_NOTHING;
    none.last = 1'b1;
    // Tick right after reset on the same day: nothing due.
    dir_beat[0] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd1);
    dir_has[0] = 1; dir_exp[0] = none;
    dir_beat[1] = make_beat(OP_REMOVE, 4'd15, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd1);
    dir_has[1] = 1; dir_exp[1] = ack(4'd15, 1'b1);
    dir_beat[2] = make_beat(OP_ADD, 4'd0, TT_ONCE, 5'd23, 6'd59, 6'd60, 5'd1);
    dir_has[2] = 1; dir_exp[2] = ack(4'd0, 1'b0);
    dir_beat[3] = make_beat(OP_ADD, 4'd0, TT_ONCE, 5'd1, 6'd0, 6'd0, 5'd1);
    dir_has[3] = 1; dir_exp[3] = ack(4'd0, 1'b1);
    dir_beat[4] = make_beat(OP_UNUSED, 4'd7, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd1);
    dir_has[4] = 1; dir_exp[4] = ack(4'd7, 1'b1);
    dir_beat[5] = make_beat(OP_ADD, 4'd15, TT_MDAY, 5'd0, 6'd0, 6'd0, 5'd1);
    dir_beat[5].mday_mask = 32'h0000_0004;
    dir_beat[6] = make_beat(OP_ADD, 4'd1, TT_MDAY, 5'd1, 6'd0, 6'd0, 5'd1);
    dir_beat[6].mday_mask = 32'h0000_0000;
    dir_beat[7] = make_beat(OP_ADD, 4'd2, TT_WEEKLY, 5'd1, 6'd0, 6'd0, 5'd1);
    dir_beat[7].wday_mask = 7'h01;
    dir_beat[8] = make_beat(OP_ADD, 4'd3, TT_MONTHLY, 5'd1, 6'd0, 6'd0, 5'd1);
    dir_beat[8].month_mask = 12'h800;
    dir_beat[9] = make_beat(OP_ADD, 4'd4, TT_ONCE, 5'd2, 6'd30, 6'd0, 5'd1);
    dir_beat[10] = make_beat(OP_REMOVE, 4'd4, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd1);
    dir_beat[11] = make_beat(OP_REMOVE, 4'd4, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd1);
    // Same-day tick: slots 1..3 pop at equal time, slot order.
    dir_beat[12] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd1, 6'd30, 6'd0, 5'd1);
    dir_beat[13] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd3, 6'd0, 6'd0, 5'd1);
    // Day change: every pending trigger due by 23:59:59 pops, pools swap.
    dir_beat[14] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd0, 6'd0, 6'd1, 5'd31);
    dir_beat[14].month = 4'd11;
    dir_beat[15] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd31, 6'd63, 6'd63, 5'd31);
    dir_beat[16] = make_beat(OP_ADD, 4'd5, TT_MDAY, 5'd31, 6'd63, 6'd63, 5'd31);
    dir_beat[17] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd0);
    dir_beat[17].day_of_week = 3'd7;
    dir_beat[17].month = 4'd15;
    dir_beat[18] = make_beat(OP_TICK, 4'd0, TT_MONTHLY, 5'd12, 6'd0, 6'd0, 5'd2);
    dir_beat[18].day_of_week = 3'd6;
    dir_beat[19] = make_beat(OP_REMOVE, 4'd1, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd2);
    dir_beat[20] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd23, 6'd0, 6'd0, 5'd3);
    dir_beat[21] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd23, 6'd0, 6'd0, 5'd4);
    dir_beat[22] = make_beat(OP_REMOVE, 4'd1, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd4);
    dir_beat[23] = make_beat(OP_TICK, 4'd0, TT_ONCE, 5'd0, 6'd0, 6'd0, 5'd5);
  endtask

  initial begin
    int        burst;
    int        sent;
    logic [4:0] dom;
    out_beat_t typed;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b1;
    errors = 0;
    cycles = 0;
    for (int i = 0; i < SLOTS; i++) begin
      held_q[i] = 1'b0;
      armed_q[i] = 1'b0;
      pool_q[i] = 1'b0;
      when_q[i] = '0;
      type_q[i] = '0;
      masks_q[i] = '0;
    end
    pend_pool = 1'b1;
    now_time = '0;
    today = 5'd1;
    fill_directed();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows; typed-in values are cross-checked with the model.
    for (int i = 0; i < 24; i++) begin
      send_beat(dir_beat[i]);
      if (dir_has[i]) begin
        typed = expected_beats[$];
        if (typed !== dir_exp[i]) begin
          errors++;
          if (errors <= 10) $display("Row %0d: table %p, model %p", i, dir_exp[i], typed);
        end
      end
    end

    // Let everything drain once before the random traffic.
    while (expected_beats.size() != 0) @(negedge clk);

    // Random traffic in bursts; ticks are mostly same-day, occasional day change.
    dom = today;
    sent = 0;
    while (sent < 180) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && sent < 180; k++) begin
        if ($urandom_range(0, 15) == 0) dom = 5'($urandom_range(1, 31));
        send_beat(random_beat(dom, $urandom_range(0, 9) == 0));
        sent++;
      end
      if (sent % 60 < 12) while (expected_beats.size() != 0) @(negedge clk);
      else repeat ($urandom_range(0, 40)) @(negedge clk);
    end

    while (expected_beats.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dtts_pkg.sv
sv/dtts_mem.sv
sv/daily_time_trigger_scheduler_unit.sv
bench/daily_time_trigger_scheduler_unit_tb.sv
